/* hw/rtl/mac_time_window_dedup_core_defines.svh */
// Assertion helpers used by the checker file.
`ifndef MAC_TIME_WINDOW_DEDUP_CORE_DEFINES_SVH
`define MAC_TIME_WINDOW_DEDUP_CORE_DEFINES_SVH

// Checked on every rising edge once reset is released.
`define MTWD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MTWD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/mtwd_pkg.sv */
package mtwd_pkg;

  localparam int unsigned ADDR_W        = 48;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned SLOT_W        = 5;
  localparam int unsigned NUM_SLOTS_DEF = 32;

  // 5 minutes in ms
  localparam logic [TIME_W-1:0] WINDOW_RST = TIME_W'(5 * 60 * 1000);

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch item, restart scan
    logic scan;      // issue next read, evaluate previous one
    logic hit_chk;   // age test on the matched slot
    logic miss_wr;   // write address and time into the victim slot
    logic clear;     // drop every slot
    logic load_out;  // move result into the output register
  } mtwd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // evaluated slot matches
    logic scan_end;  // evaluated slot is the last one
    logic out_free;  // output register can take a result
  } mtwd_sts_t;

endpackage

/* hw/rtl/mtwd_req_if.sv */
interface mtwd_req_if;
  import mtwd_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] mac_addr;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output operation, output mac_addr, output now_ms,
                  input ready);
  modport sink   (input valid, input operation, input mac_addr, input now_ms,
                  output ready);
endinterface

/* hw/rtl/mtwd_rsp_if.sv */
interface mtwd_rsp_if;
  import mtwd_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic [SLOT_W-1:0] slot_index;
  logic              was_present;

  modport source (output valid, output accepted, output slot_index, output was_present,
                  input ready);
  modport sink   (input valid, input accepted, input slot_index, input was_present,
                  output ready);
endinterface

/* hw/rtl/mtwd_ram.sv */
module mtwd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* hw/rtl/mtwd_ctrl.sv */
module mtwd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  input  mtwd_pkg::mtwd_sts_t sts_i,
  output mtwd_pkg::mtwd_cmd_t cmd_o
);
  import mtwd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_HIT  = 5'b00100,
    ST_MISS = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e    state_q, state_d;
  mtwd_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_CLEAR) begin
            cmd.clear = 1'b1;
            state_d   = ST_DONE;
          end else begin
            cmd.start = 1'b1;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        priority if (sts_i.hit) begin
          state_d = ST_HIT;
        end else if (sts_i.scan_end) begin
          state_d = ST_MISS;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_HIT: begin
        cmd.hit_chk = 1'b1;
        state_d     = ST_DONE;
      end
      ST_MISS: begin
        cmd.miss_wr = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd;
endmodule

/* hw/rtl/mtwd_dpath.sv */
module mtwd_dpath #(
  parameter int unsigned NUM_SLOTS = mtwd_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mtwd_pkg::TIME_W-1:0] cfg_wdata_i,
  input  logic [mtwd_pkg::ADDR_W-1:0] mac_addr_i,
  input  logic [mtwd_pkg::TIME_W-1:0] now_ms_i,
  input  mtwd_pkg::mtwd_cmd_t         cmd_i,
  output mtwd_pkg::mtwd_sts_t         sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_accepted_o,
  output logic [mtwd_pkg::SLOT_W-1:0] out_slot_index_o,
  output logic                        out_was_present_o
);
  import mtwd_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_SLOTS);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(NUM_SLOTS - 1);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(NUM_SLOTS);

  logic [TIME_W-1:0]    window_q;
  logic [ADDR_W-1:0]    mac_q;
  logic [TIME_W-1:0]    now_q;
  logic [CntW-1:0]      cnt_q;
  logic                 ev_vld_q;
  logic [IdxW-1:0]      ev_idx_q;
  logic [TIME_W-1:0]    best_q;
  logic [IdxW-1:0]      sel_q;
  logic [TIME_W-1:0]    hit_time_q;
  logic [NUM_SLOTS-1:0] valid_q;
  logic                 res_acc_q, res_pres_q;
  logic [SLOT_W-1:0]    res_slot_q;
  logic                 out_vld_q, out_acc_q, out_pres_q;
  logic [SLOT_W-1:0]    out_slot_q;

  logic              issue, slot_vld, hit, take, expired;
  logic [IdxW-1:0]   raddr;
  logic [ADDR_W-1:0] addr_rd;
  logic [TIME_W-1:0] time_rd, age;
  logic              addr_we, time_we;

  assign issue    = cmd_i.scan && (cnt_q < SlotsCnt);
  assign raddr    = cnt_q[IdxW-1:0];
  assign slot_vld = valid_q[ev_idx_q];
  assign hit      = ev_vld_q && slot_vld && (addr_rd == mac_q);
  // invalid slots count as time zero, so they always win the victim search
  assign take     = !slot_vld || (time_rd < best_q);
  assign age      = now_q - hit_time_q;
  assign expired  = !(age < window_q);
  assign addr_we  = cmd_i.miss_wr;
  assign time_we  = cmd_i.miss_wr || (cmd_i.hit_chk && expired);

  mtwd_ram #(.WIDTH(ADDR_W), .DEPTH(NUM_SLOTS)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .waddr_i (sel_q),
    .wdata_i (mac_q),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (addr_rd)
  );

  mtwd_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (sel_q),
    .wdata_i (now_q),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (time_rd)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WINDOW_RST;
      valid_q   <= '0;
      cnt_q     <= '0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (cmd_i.miss_wr) begin
        valid_q[sel_q] <= 1'b1;
      end
      if (cmd_i.start) begin
        cnt_q    <= '0;
        ev_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        ev_vld_q <= issue;
        if (issue) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mac_q  <= mac_addr_i;
      now_q  <= now_ms_i;
      best_q <= '1;
      sel_q  <= '0;
    end
    if (cmd_i.scan) begin
      ev_idx_q <= raddr;
      if (hit) begin
        sel_q      <= ev_idx_q;
        hit_time_q <= time_rd;
      end else if (ev_vld_q && take) begin
        sel_q  <= ev_idx_q;
        best_q <= slot_vld ? time_rd : '0;
      end
    end
    if (cmd_i.hit_chk) begin
      res_acc_q  <= expired;
      res_pres_q <= 1'b1;
      res_slot_q <= SLOT_W'(sel_q);
    end
    if (cmd_i.miss_wr) begin
      res_acc_q  <= 1'b1;
      res_pres_q <= 1'b0;
      res_slot_q <= SLOT_W'(sel_q);
    end
    if (cmd_i.clear) begin
      res_acc_q  <= 1'b0;
      res_pres_q <= 1'b0;
      res_slot_q <= '0;
    end
    if (cmd_i.load_out) begin
      out_acc_q  <= res_acc_q;
      out_pres_q <= res_pres_q;
      out_slot_q <= res_slot_q;
    end
  end

  assign sts_o.hit      = hit;
  assign sts_o.scan_end = ev_vld_q && (ev_idx_q == LastIdx);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o       = out_vld_q;
  assign out_accepted_o    = out_acc_q;
  assign out_slot_index_o  = out_slot_q;
  assign out_was_present_o = out_pres_q;
endmodule

/* hw/rtl/mac_time_window_dedup_core.sv */
// Sequencing: a clear item goes straight to the output register; a check item scans
//   the slots up to a match or the last slot, then tests the match or writes a victim.
// Throughput: one item at a time; a check item is paced by the slot scan through the
//   single read port of the RAMs, and its result waits for a free output register.
// Reset (rst_ni, async, active low): all slots invalid, window back to 300000 ms,
//   no result pending. No clearing pass is needed.
module mac_time_window_dedup_core #(
  parameter int unsigned NUM_SLOTS = mtwd_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mtwd_pkg::TIME_W-1:0] cfg_wdata_i,
  mtwd_req_if.sink                    req_i,
  mtwd_rsp_if.source                  rsp_o
);
  import mtwd_pkg::*;

  // Controller and datapath talk only through these two bundles.
  mtwd_cmd_t cmd;
  mtwd_sts_t sts;

  // The controller owns sequencing: idle -> scan -> hit test or victim write
  // -> hand the result to the output register. A clear item skips the scan.
  mtwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.operation),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the window register, the slot RAMs, the valid bits,
  // the victim search and the output register. The output register decouples
  // the result beat from the next request beat: a new item can be taken while
  // the previous result still waits for the sink.
  mtwd_dpath #(.NUM_SLOTS(NUM_SLOTS)) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mac_addr_i        (req_i.mac_addr),
    .now_ms_i          (req_i.now_ms),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .out_accepted_o    (rsp_o.accepted),
    .out_slot_index_o  (rsp_o.slot_index),
    .out_was_present_o (rsp_o.was_present)
  );
endmodule

/* hw/rtl/mtwd_checker.sv */
`include "mac_time_window_dedup_core_defines.svh"

module mtwd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_accepted_i,
  input logic [mtwd_pkg::SLOT_W-1:0] rsp_slot_index_i,
  input logic                        rsp_was_present_i
);
  import mtwd_pkg::*;

  // a stalled result beat holds
  `MTWD_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_accepted_i) && $stable(rsp_slot_index_i) && $stable(rsp_was_present_i), "result beat changed while stalled")

  // one item in flight: no request is taken right after one was taken
  `MTWD_ASSERT(a_one_item, req_valid_i && req_ready_i |=> !req_ready_i, "request taken while busy")

  // a new address is always reported; only a clear gives neither flag
  `MTWD_ASSERT(a_clear_shape, rsp_valid_i && !rsp_accepted_i && !rsp_was_present_i |-> rsp_slot_index_i == '0, "suppressed result without a held address")

  // nothing is offered during reset
  `MTWD_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !rsp_valid_i, "result valid during reset")
endmodule

bind mac_time_window_dedup_core mtwd_checker u_mtwd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_accepted_i    (rsp_o.accepted),
  .rsp_slot_index_i  (rsp_o.slot_index),
  .rsp_was_present_i (rsp_o.was_present)
);

/* tb/tb_mac_time_window_dedup_core.sv */
`timescale 1ns / 1ps

module tb_mac_time_window_dedup_core;
  import mtwd_pkg::*;

  localparam int unsigned SLOTS           = NUM_SLOTS_DEF;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 135;
  localparam int unsigned POOL_MAX        = 48;
  // one long receiver hold-off, once this many result beats have gone by
  localparam int unsigned HOLD_AT_BEAT    = 300;
  localparam int unsigned HOLD_CYCLES     = 400;
  // no beat on either side for this long means the block is stuck
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  // worst case scan plus slack, used for the quiet period at the end
  localparam int unsigned DRAIN_CYCLES    = SLOTS + 8;

  // Named addresses used in the directed rows.
  localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [ADDR_W-1:0] ADDR_ONE  = 48'h0000_0000_0001;
  localparam logic [ADDR_W-1:0] ADDR_MSB  = 48'h8000_0000_0000;
  localparam logic [ADDR_W-1:0] ADDR_P    = 48'h0123_4567_89AB;
  localparam logic [ADDR_W-1:0] ADDR_Q    = 48'hFEDC_BA98_7654;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] mac_addr;
    logic [TIME_W-1:0] now_ms;
  } dedup_req_t;

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] slot_index;
    logic              was_present;
  } dedup_rsp_t;

  // Directed row: the request, plus a hand-written verdict where known is set.
  typedef struct packed {
    dedup_req_t req;
    logic       known;
    dedup_rsp_t verdict;
  } dir_row_t;

  localparam int unsigned DIR_N = 17;

  // Rows run under the reset window of 300000 ms.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty table: the highest invalid slot takes the first address
    '{'{OP_CHECK, ADDR_ZERO, 32'd0},          1'b1, '{1'b1, 5'd31, 1'b0}},
    // same address, age zero: suppressed
    '{'{OP_CHECK, ADDR_ZERO, 32'd0},          1'b1, '{1'b0, 5'd31, 1'b1}},
    // field extremes, goes to the next invalid slot down
    '{'{OP_CHECK, ADDR_ONES, 32'hFFFF_FFFF},  1'b1, '{1'b1, 5'd30, 1'b0}},
    // age one below the window: still suppressed
    '{'{OP_CHECK, ADDR_ZERO, 32'd299999},     1'b1, '{1'b0, 5'd31, 1'b1}},
    // age equal to the window: reported again, time refreshed
    '{'{OP_CHECK, ADDR_ZERO, 32'd300000},     1'b1, '{1'b1, 5'd31, 1'b1}},
    // age across the 32-bit wrap is small: suppressed
    '{'{OP_CHECK, ADDR_ONES, 32'h0000_0010},  1'b1, '{1'b0, 5'd30, 1'b1}},
    '{'{OP_CHECK, ADDR_MSB,  32'h7FFF_FFFF},  1'b1, '{1'b1, 5'd29, 1'b0}},
    '{'{OP_CHECK, ADDR_ONE,  32'd12345},      1'b0, '0},
    // clear ignores its address and time fields
    '{'{OP_CLEAR, ADDR_ONES, 32'hFFFF_FFFF},  1'b1, '{1'b0, 5'd0,  1'b0}},
    // everything forgotten after the clear
    '{'{OP_CHECK, ADDR_ONES, 32'd5},          1'b1, '{1'b1, 5'd31, 1'b0}},
    '{'{OP_CHECK, ADDR_ZERO, 32'h8000_0000},  1'b1, '{1'b1, 5'd30, 1'b0}},
    '{'{OP_CLEAR, ADDR_ZERO, 32'd0},          1'b1, '{1'b0, 5'd0,  1'b0}},
    '{'{OP_CHECK, ADDR_P,    32'd100},        1'b0, '0},
    '{'{OP_CHECK, ADDR_Q,    32'd200},        1'b0, '0},
    '{'{OP_CHECK, ADDR_P,    32'd300100},     1'b0, '0},
    '{'{OP_CHECK, ADDR_P,    32'd300101},     1'b0, '0},
    // differs from an address seen before only in bit 0
    '{'{OP_CHECK, ADDR_ONE,  32'd1},          1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic              cfg_we_i;
  logic [TIME_W-1:0] cfg_wdata_i;

  mtwd_req_if req_if ();
  mtwd_rsp_if rsp_if ();

  mac_time_window_dedup_core #(
    .NUM_SLOTS (SLOTS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the slot table and window, updated in acceptance order.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] slot_addr_q [SLOTS];
  logic [TIME_W-1:0] slot_time_q [SLOTS];
  logic              slot_vld_q  [SLOTS];
  logic [TIME_W-1:0] window_q;

  // Verdicts still owed by the block, oldest first.
  dedup_rsp_t verdict_q [$];

  int unsigned mismatch_cnt;
  int unsigned rsp_beats;
  // 0 = no idling on either side, else roughly one idle burst in idle_odds beats
  int unsigned idle_odds;

  function automatic void clear_slot_model();
    for (int i = 0; i < SLOTS; i++) begin
      slot_addr_q[i] = '0;
      slot_time_q[i] = '0;
      slot_vld_q[i]  = 1'b0;
    end
  endfunction

  // Look up an address, apply the window and pick a victim on a miss.
  function automatic dedup_rsp_t predict_dedup(input dedup_req_t r);
    dedup_rsp_t        res;
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] age;
    int unsigned       victim;
    res = '0;
    if (r.operation == OP_CLEAR) begin
      clear_slot_model();
      return res;
    end
    oldest = '1;
    victim = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_vld_q[i] && slot_addr_q[i] == r.mac_addr) begin
        // modular age, so a time that wrapped past zero still looks recent
        age             = r.now_ms - slot_time_q[i];
        res.slot_index  = SLOT_W'(i);
        res.was_present = 1'b1;
        if (age >= window_q) begin
          slot_time_q[i] = r.now_ms;
          res.accepted   = 1'b1;
        end
        return res;
      end
      // invalid slots hold time zero; the time compare here is plain, no wrap
      if (!slot_vld_q[i] || slot_time_q[i] < oldest) begin
        oldest = slot_time_q[i];
        victim = i;
      end
    end
    slot_addr_q[victim] = r.mac_addr;
    slot_time_q[victim] = r.now_ms;
    slot_vld_q[victim]  = 1'b1;
    res.accepted        = 1'b1;
    res.slot_index      = SLOT_W'(victim);
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ADDR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Request side: offer one beat, wait for the handshake, then predict.
  // Called at a rising edge; returns at the edge that took the beat.
  // ---------------------------------------------------------------------------
  task automatic issue_req(input dedup_req_t r, input logic known, input dedup_rsp_t typed);
    dedup_rsp_t predicted;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= r.operation;
    req_if.mac_addr  <= r.mac_addr;
    req_if.now_ms    <= r.now_ms;
    do @(posedge clk_i); while (!req_if.ready);
    // the shadow table moves on every beat, even when the verdict is typed in
    predicted = predict_dedup(r);
    verdict_q.push_back(known ? typed : predicted);
  endtask

  // Window writes only with the block idle: every verdict back, nothing offered.
  task automatic set_window(input logic [TIME_W-1:0] w);
    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    window_q     = w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: ready with random stall bursts, plus one long hold-off so
  // the output register stays full and the request side backs up.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    logic        hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && rsp_beats >= HOLD_AT_BEAT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
        stall_left = $urandom_range(0, 5);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each beat against the oldest owed verdict.
  // ---------------------------------------------------------------------------
  initial begin
    dedup_rsp_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        rsp_beats++;
        if (verdict_q.size() == 0) begin
          $error("result beat with no verdict owed: accepted %0d slot_index %0d was_present %0d",
                 rsp_if.accepted, rsp_if.slot_index, rsp_if.was_present);
          mismatch_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (rsp_if.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, rsp_if.accepted);
            mismatch_cnt++;
          end
          if (rsp_if.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, rsp_if.slot_index);
            mismatch_cnt++;
          end
          if (rsp_if.was_present !== want.was_present) begin
            $error("was_present: expected %0d, got %0d", want.was_present, rsp_if.was_present);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles without a beat on either channel.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("mac_time_window_dedup_core test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dedup_req_t        r;
    logic [ADDR_W-1:0] pool [POOL_MAX];
    logic [ADDR_W-1:0] last_addr;
    logic [TIME_W-1:0] now_q;
    logic [TIME_W-1:0] win;
    int unsigned       pool_n;
    int unsigned       span;
    int unsigned       roll;

    mismatch_cnt = 0;
    rsp_beats    = 0;
    idle_odds    = 4;
    last_addr    = '0;
    clear_slot_model();
    window_q = WINDOW_RST;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_CHECK;
    req_if.mac_addr  <= '0;
    req_if.now_ms    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset window.
    foreach (DIR_ROWS[k]) begin
      issue_req(DIR_ROWS[k].req, DIR_ROWS[k].known, DIR_ROWS[k].verdict);
    end

    // Random part. Each phase has its own window, address pool and time base.
    // Most beats re-report addresses from a pool, so hits, refreshes and
    // suppressions dominate; pools above the slot count force evictions.
    for (int phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      case (phase_idx)
        0:       win = WINDOW_RST;
        1:       win = '0;               // nothing is ever suppressed
        2:       win = '1;               // nearly everything is suppressed
        3:       win = 32'd1;
        4:       win = $urandom_range(2, 5000);
        5:       win = $urandom;
        6:       win = 32'd1000;
        default: win = WINDOW_RST;
      endcase
      set_window(win);

      // last phase runs with no idling anywhere
      if (phase_idx == PHASES - 1) begin
        idle_odds = 0;
      end else begin
        idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
      end

      span = (win == 0) ? 64 : (win > 400000) ? 400000 : win;
      // sometimes start just below the 32-bit wrap of the time
      now_q = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8 * span)
                                          : $urandom;

      pool_n = $urandom_range(3, POOL_MAX);
      for (int k = 0; k < POOL_MAX; k++) begin
        // some pool entries differ from their neighbor in a single bit
        pool[k] = (k > 0 && $urandom_range(0, 3) == 0)
                ? pool[k-1] ^ (48'h1 << $urandom_range(0, ADDR_W - 1))
                : rand_addr();
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll        = $urandom_range(0, 99);
        r.operation = OP_CHECK;
        if (roll < 2) begin
          r.operation = OP_CLEAR;
          r.mac_addr  = rand_addr();
          r.now_ms    = $urandom;
        end else begin
          if (roll < 10) begin
            // same address again, exactly at or one short of the window
            r.mac_addr = last_addr;
            now_q      = now_q + ((roll < 6) ? win : win - 1);
          end else begin
            now_q      = now_q + ((roll < 14) ? $urandom : $urandom_range(0, 2 * span));
            r.mac_addr = (roll < 19) ? rand_addr() : pool[$urandom_range(0, pool_n - 1)];
          end
          r.now_ms  = now_q;
          last_addr = r.mac_addr;
        end
        issue_req(r, 1'b0, '0);
      end
    end
    req_if.valid <= 1'b0;

    // Drain, then give a stray late beat time to show up.
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("mac_time_window_dedup_core test passed");
    end else begin
      $display("mac_time_window_dedup_core test failed");
    end
    $finish;
  end

endmodule
